// File: rtl/core/brs_pkg.sv
// shared constants, operation codes, controller states and the
// command/status structs used between the controller and the datapath
// no dependencies
package brs_pkg;

   localparam int CAPACITY_BITS  = 4096;
   localparam int WORD_BITS      = 64;
   localparam int NUM_WORDS      = CAPACITY_BITS / WORD_BITS;
   localparam int WADDR_W        = $clog2(NUM_WORDS);
   localparam int OFFS_W         = $clog2(WORD_BITS);
   localparam int BYTES_PER_WORD = WORD_BITS / 8;
   localparam int BYTE_SEL_W     = $clog2(BYTES_PER_WORD);
   localparam int STORE_BYTES    = CAPACITY_BITS / 8;
   localparam int CNT_W          = WADDR_W + 1;
   localparam int PCNT_W         = OFFS_W + 1;

   localparam int OP_W       = 3;
   localparam int INDEX_W    = 12;
   localparam int NTH_W      = 13;
   localparam int ACT_W      = 10;
   localparam int POSITION_W = 12;
   localparam int COUNT_W    = 13;

   typedef enum logic [OP_W-1:0] {
      OP_TEST   = 3'd0,
      OP_SET    = 3'd1,
      OP_CLEAR  = 3'd2,
      OP_SELECT = 3'd3,
      OP_RANK   = 3'd4,
      OP_FILL   = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD,
      ST_RMW,
      ST_SCAN,
      ST_SEL,
      ST_FILL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               load;
      logic               rd_en;
      logic               use_idx;
      logic [WADDR_W-1:0] addr;
      logic               rmw;
      logic               sel_step;
      logic               fill_wr;
   } cmd_type;

   typedef struct packed {
      logic found;
      logic sel_done;
      logic scan_last;
   } stat_type;

endpackage

// File: rtl/core/brs_ctrl.sv
// controller state machine: sequences read-modify-write, scans, the
// in-word select search and fill sweeps
// depends on brs_pkg
module brs_ctrl import brs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [OP_W-1:0]   req_op,
   input  stat_type          stat,
   output cmd_type           cmd,
   output logic              busy,
   output logic              rsp_strobe
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state and word counter
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (start) begin
               case (req_op)
                  OP_TEST, OP_SET, OP_CLEAR: state_in = ST_RD;
                  OP_SELECT, OP_RANK:        state_in = ST_SCAN;
                  OP_FILL:                   state_in = ST_FILL;
                  default:                   state_in = ST_DONE;
               endcase
            end
         end
         ST_RD: begin
            state_in = ST_RMW;
         end
         ST_RMW: begin
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            if (!cnt_ff[CNT_W-1]) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (stat.found) begin
               state_in = ST_SEL;
            end else if (stat.scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_SEL: begin
            if (stat.sel_done) begin
               state_in = ST_DONE;
            end
         end
         ST_FILL: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[WADDR_W-1:0] == WADDR_W'(NUM_WORDS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands and handshake outputs
   always_comb begin
      cmd        = '0;
      cmd.addr   = cnt_ff[WADDR_W-1:0];
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.use_idx = 1'b1;
         end
         ST_RMW: begin
            cmd.rmw = 1'b1;
         end
         ST_SCAN: begin
            cmd.rd_en = !cnt_ff[CNT_W-1];
         end
         ST_SEL: begin
            cmd.sel_step = 1'b1;
         end
         ST_FILL: begin
            cmd.fill_wr = 1'b1;
         end
         ST_DONE: begin
            rsp_strobe = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// File: rtl/core/brs_datapath.sv
// datapath: bit store memory with row valid bits, request and config
// registers, popcount scan, in-word select search and fill pattern
// depends on brs_pkg
module brs_datapath import brs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output stat_type              stat,
   input  logic [OP_W-1:0]       req_op,
   input  logic [INDEX_W-1:0]    req_index,
   input  logic [NTH_W-1:0]      req_nth,
   input  logic                  req_fill_value,
   input  logic                  csr_valid,
   input  logic [ACT_W-1:0]      csr_active_bytes,
   output logic                  status,
   output logic                  bit_value,
   output logic [POSITION_W-1:0] position,
   output logic [COUNT_W-1:0]    ones_count
);

   function automatic logic [3:0] pop8(input logic [7:0] v);
      logic [3:0] c;
      c = '0;
      for (int k = 0; k < 8; k++) begin
         c = c + 4'(v[k]);
      end
      return c;
   endfunction

   function automatic logic [PCNT_W-1:0] pop_word(input logic [WORD_BITS-1:0] v);
      logic [PCNT_W-1:0] c;
      c = '0;
      for (int b = 0; b < BYTES_PER_WORD; b++) begin
         c = c + PCNT_W'(pop8(v[8*b +: 8]));
      end
      return c;
   endfunction

   // offset of the n-th one bit inside a byte, lowest position first
   function automatic logic [2:0] find_nth8(input logic [7:0] v, input logic [3:0] n);
      logic [3:0] c;
      logic [2:0] k_out;
      logic       got;
      c     = '0;
      k_out = '0;
      got   = 1'b0;
      for (int k = 0; k < 8; k++) begin
         if (v[k]) begin
            c = c + 1'b1;
            if (!got && c == n) begin
               k_out = 3'(k);
               got   = 1'b1;
            end
         end
      end
      return k_out;
   endfunction

   logic [WORD_BITS-1:0]  mem [NUM_WORDS];
   logic [NUM_WORDS-1:0]  valid_ff;
   logic [WORD_BITS-1:0]  mem_q_ff;
   logic                  rvalid_ff;
   logic                  dv_ff;
   logic [WADDR_W-1:0]    daddr_ff;
   logic                  last_ff;
   logic [ACT_W-1:0]      csr_active_ff;

   op_type                op_ff;
   logic [INDEX_W-1:0]    index_ff;
   logic [NTH_W-1:0]      nth_ff;
   logic                  fv_ff;

   logic [NTH_W-1:0]      seen_ff;
   logic                  found_ff;
   logic [WORD_BITS-1:0]  sel_word_ff;
   logic [WADDR_W-1:0]    sel_waddr_ff;
   logic [PCNT_W-1:0]     rem_ff;
   logic [BYTE_SEL_W-1:0] byte_ff;
   logic                  sel_done_ff;

   logic                  status_ff;
   logic                  bit_ff;
   logic [POSITION_W-1:0] pos_ff;
   logic [COUNT_W-1:0]    count_ff;

   logic [WADDR_W-1:0]    rd_addr;
   logic [WORD_BITS-1:0]  word;
   logic [WADDR_W-1:0]    tw;
   logic [OFFS_W-1:0]     off;
   logic [WORD_BITS-1:0]  rank_mask;
   logic [WORD_BITS-1:0]  rank_word;
   logic                  is_rank;
   logic                  is_sel;
   logic [PCNT_W-1:0]     pc;
   logic                  proc;
   logic [NTH_W:0]        sum;
   logic                  hit;
   logic [WORD_BITS-1:0]  mod_word;
   logic [WORD_BITS-1:0]  fill_word;
   logic [ACT_W-1:0]      act;
   logic                  wr_en;
   logic [WADDR_W-1:0]    wr_addr;
   logic [WORD_BITS-1:0]  wr_data;
   logic [7:0]            sel_byte;
   logic [3:0]            pc8;
   logic                  sel_hit;
   logic [2:0]            sel_k;

   assign rd_addr = cmd.use_idx ? index_ff[INDEX_W-1 -: WADDR_W] : cmd.addr;
   assign word    = rvalid_ff ? mem_q_ff : '0;
   assign tw      = index_ff[INDEX_W-1 -: WADDR_W];
   assign off     = index_ff[OFFS_W-1:0];
   assign is_rank = (op_ff == OP_RANK);
   assign is_sel  = (op_ff == OP_SELECT);

   // rank counts positions up to and including the index offset
   assign rank_mask = {WORD_BITS{1'b1}} >> (OFFS_W'(WORD_BITS - 1) - off);

   always_comb begin
      if (daddr_ff < tw) begin
         rank_word = word;
      end else if (daddr_ff == tw) begin
         rank_word = word & rank_mask;
      end else begin
         rank_word = '0;
      end
   end

   assign pc   = pop_word(is_rank ? rank_word : word);
   assign proc = dv_ff && (is_rank || (is_sel && !found_ff));
   assign sum  = {1'b0, seen_ff} + (NTH_W+1)'(pc);
   assign hit  = (nth_ff != '0) && (sum >= {1'b0, nth_ff});

   always_comb begin
      mod_word      = word;
      mod_word[off] = (op_ff == OP_SET);
   end

   assign act = (csr_active_ff > ACT_W'(STORE_BYTES)) ? ACT_W'(STORE_BYTES) : csr_active_ff;

   always_comb begin
      for (int j = 0; j < BYTES_PER_WORD; j++) begin
         fill_word[8*j +: 8] =
            {8{fv_ff && (ACT_W'({cmd.addr, BYTE_SEL_W'(j)}) < act)}};
      end
   end

   always_comb begin
      wr_en   = cmd.fill_wr || (cmd.rmw && (op_ff == OP_SET || op_ff == OP_CLEAR));
      wr_addr = cmd.fill_wr ? cmd.addr : tw;
      wr_data = cmd.fill_wr ? fill_word : mod_word;
   end

   assign sel_byte = sel_word_ff[8*byte_ff +: 8];
   assign pc8      = pop8(sel_byte);
   assign sel_hit  = (PCNT_W'(pc8) >= rem_ff);
   assign sel_k    = find_nth8(sel_byte, rem_ff[3:0]);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         dv_ff         <= 1'b0;
         last_ff       <= 1'b0;
         found_ff      <= 1'b0;
         sel_done_ff   <= 1'b0;
         csr_active_ff <= '0;
      end else begin
         dv_ff   <= cmd.rd_en;
         last_ff <= dv_ff && (daddr_ff == WADDR_W'(NUM_WORDS - 1));
         if (csr_valid) begin
            csr_active_ff <= csr_active_bytes;
         end
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.load) begin
            found_ff    <= 1'b0;
            sel_done_ff <= 1'b0;
         end else begin
            if (proc && is_sel && hit) begin
               found_ff <= 1'b1;
            end
            if (cmd.sel_step && !sel_done_ff && sel_hit) begin
               sel_done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         daddr_ff  <= rd_addr;
         rvalid_ff <= valid_ff[rd_addr];
      end
      if (cmd.load) begin
         op_ff     <= op_type'(req_op);
         index_ff  <= req_index;
         nth_ff    <= req_nth;
         fv_ff     <= req_fill_value;
         seen_ff   <= '0;
         status_ff <= 1'b0;
         bit_ff    <= 1'b0;
         pos_ff    <= '0;
         count_ff  <= '0;
      end else begin
         if (cmd.rmw && op_ff == OP_TEST) begin
            bit_ff <= word[off];
         end
         if (proc) begin
            if (is_rank) begin
               count_ff <= count_ff + COUNT_W'(pc);
            end else if (hit) begin
               sel_word_ff  <= word;
               sel_waddr_ff <= daddr_ff;
               rem_ff       <= PCNT_W'(nth_ff - seen_ff);
               byte_ff      <= '0;
            end else begin
               seen_ff <= seen_ff + NTH_W'(pc);
            end
         end
         // whole store scanned without reaching the n-th one bit
         if (is_sel && last_ff && !found_ff) begin
            status_ff <= 1'b1;
         end
         if (cmd.sel_step && !sel_done_ff) begin
            if (sel_hit) begin
               pos_ff <= {sel_waddr_ff, byte_ff, sel_k};
            end else begin
               rem_ff  <= rem_ff - PCNT_W'(pc8);
               byte_ff <= byte_ff + 1'b1;
            end
         end
      end
   end

   assign stat.found     = found_ff;
   assign stat.sel_done  = sel_done_ff;
   assign stat.scan_last = last_ff;

   assign status     = status_ff;
   assign bit_value  = bit_ff;
   assign position   = pos_ff;
   assign ones_count = count_ff;

endmodule

// File: rtl/core/bitmap_rank_select.sv
// top level of the 4096-bit rank/select bit vector
// depends on brs_pkg, brs_ctrl and brs_datapath
//
// A request is taken when start is high and busy is low; its single result
// appears for one cycle with rsp_strobe high and cannot be held off, so the
// receiver must take it then. The store is a 64 x 64-bit memory with one
// read and one write port, and that port pair sets the timing: test, set
// and clear read the addressed word in ST_RD, and set and clear write it
// back in ST_RMW; rank, and a select that finds nothing, scan all 64 words
// at one word a cycle; a select that finds its bit stops the scan at that
// word and then walks it a byte per cycle; fill writes every word. busy is
// low again the cycle after the strobe. The store needs no clearing pass
// after reset. csr_ready is always high; write csr_active_bytes only while
// busy is low.
module bitmap_rank_select import brs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_op,
   input  logic [INDEX_W-1:0]    req_index,
   input  logic [NTH_W-1:0]      req_nth,
   input  logic                  req_fill_value,
   output logic                  rsp_strobe,
   output logic                  rsp_status,
   output logic                  rsp_bit_value,
   output logic [POSITION_W-1:0] rsp_position,
   output logic [COUNT_W-1:0]    rsp_ones_count,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [ACT_W-1:0]      csr_active_bytes
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   brs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_op     (req_op),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   brs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_op           (req_op),
      .req_index        (req_index),
      .req_nth          (req_nth),
      .req_fill_value   (req_fill_value),
      .csr_valid        (csr_valid && csr_ready),
      .csr_active_bytes (csr_active_bytes),
      .status           (rsp_status),
      .bit_value        (rsp_bit_value),
      .position         (rsp_position),
      .ones_count       (rsp_ones_count)
   );

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted request");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!rsp_strobe && !busy))
      else $error("result strobe longer than one cycle or block stuck busy");

   a_error_position: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status) |-> (rsp_position == '0))
      else $error("failed select reports a nonzero position");
`endif

endmodule

// File: sim/bitmap_rank_select_tb.sv
// self-checking testbench for the bitmap_rank_select bit vector block
// depends on brs_pkg and the rtl of bitmap_rank_select; carries its own
// predictor of the bit store, a directed table and a random request mix
`timescale 1ns / 100ps

module bitmap_rank_select_tb import brs_pkg::*; ();

   // op codes the block leaves undefined: no state change, all-zero result
   localparam logic [OP_W-1:0] OP_UNDEF6 = 3'd6;
   localparam logic [OP_W-1:0] OP_UNDEF7 = 3'd7;

   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 190;
   localparam int DRAIN_CYCLES    = 80;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int MAX_REPORTS     = 10;

   typedef struct packed {
      logic                  status;
      logic                  bit_value;
      logic [POSITION_W-1:0] position;
      logic [COUNT_W-1:0]    ones_count;
   } answer_type;

   typedef struct {
      bit                 csr_write;
      logic [ACT_W-1:0]   csr_value;
      logic [OP_W-1:0]    op;
      logic [INDEX_W-1:0] index;
      logic [NTH_W-1:0]   nth;
      logic               fill_value;
      bit                 known;
      answer_type         answer;
   } script_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [OP_W-1:0]       req_op = '0;
   logic [INDEX_W-1:0]    req_index = '0;
   logic [NTH_W-1:0]      req_nth = '0;
   logic                  req_fill_value = 1'b0;
   logic                  rsp_strobe;
   logic                  rsp_status;
   logic                  rsp_bit_value;
   logic [POSITION_W-1:0] rsp_position;
   logic [COUNT_W-1:0]    rsp_ones_count;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [ACT_W-1:0]      csr_active_bytes = '0;

   // predictor state: bit p is bit 7-(p%8) of byte p/8
   logic [7:0]       bit_bytes [STORE_BYTES];
   logic [ACT_W-1:0] active_limit;
   answer_type       answers_due [$];
   int               mismatches = 0;
   int               cycle_count = 0;

   bitmap_rank_select dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_index        (req_index),
      .req_nth          (req_nth),
      .req_fill_value   (req_fill_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_bit_value    (rsp_bit_value),
      .rsp_position     (rsp_position),
      .rsp_ones_count   (rsp_ones_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_active_bytes (csr_active_bytes)
   );

   always #1 clock = ~clock;

   function automatic int ones_through(input int last);
      int total = 0;
      for (int b = 0; b < (last >> 3); b++) total += $countones(bit_bytes[b]);
      for (int p = last & ~7; p <= last; p++) total += bit_bytes[p >> 3][7 - (p & 7)];
      return total;
   endfunction

   // applies one request to the predicted store and returns its result
   function automatic answer_type bitmap_answer(input logic [OP_W-1:0] op,
                                                input logic [INDEX_W-1:0] idx,
                                                input logic [NTH_W-1:0] nth,
                                                input logic fv);
      answer_type ans = '0;
      int seen = 0;
      int fill_bytes;
      case (op)
         OP_TEST: ans.bit_value = bit_bytes[idx >> 3][7 - idx[2:0]];
         OP_SET: bit_bytes[idx >> 3][7 - idx[2:0]] = 1'b1;
         OP_CLEAR: bit_bytes[idx >> 3][7 - idx[2:0]] = 1'b0;
         OP_SELECT: begin
            ans.status = 1'b1;
            if (nth != 0) begin
               for (int p = 0; p < CAPACITY_BITS && ans.status; p++) begin
                  seen += bit_bytes[p >> 3][7 - (p & 7)];
                  if (seen == nth) begin
                     ans.status = 1'b0;
                     ans.position = POSITION_W'(p);
                  end
               end
            end
         end
         OP_RANK: ans.ones_count = COUNT_W'(ones_through(idx));
         OP_FILL: begin
            fill_bytes = (int'(active_limit) > STORE_BYTES) ? STORE_BYTES
                                                            : int'(active_limit);
            for (int b = 0; b < STORE_BYTES; b++)
               bit_bytes[b] = (fv && b < fill_bytes) ? 8'hFF : 8'h00;
         end
         default: ;
      endcase
      return ans;
   endfunction

   function automatic script_row_type plain_row(input logic [OP_W-1:0] op, input int idx,
                                                input int nth, input logic fv);
      script_row_type r;
      r.csr_write = 1'b0;
      r.csr_value = '0;
      r.op = op;
      r.index = INDEX_W'(idx);
      r.nth = NTH_W'(nth);
      r.fill_value = fv;
      r.known = 1'b0;
      r.answer = '0;
      return r;
   endfunction

   function automatic script_row_type known_row(input logic [OP_W-1:0] op, input int idx,
                                                input int nth, input logic fv,
                                                input logic st, input logic bv,
                                                input int pos, input int cnt);
      script_row_type r = plain_row(op, idx, nth, fv);
      r.known = 1'b1;
      r.answer = {st, bv, POSITION_W'(pos), COUNT_W'(cnt)};
      return r;
   endfunction

   function automatic script_row_type csr_row(input int value);
      script_row_type r = plain_row(OP_TEST, 0, 0, 1'b0);
      r.csr_write = 1'b1;
      r.csr_value = ACT_W'(value);
      return r;
   endfunction

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // called at a falling edge; returns at the falling edge after the request is taken
   task automatic issue_request(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                                input logic [NTH_W-1:0] nth, input logic fv,
                                input bit known, input answer_type known_answer);
      answer_type predicted;
      start <= 1'b1;
      req_op <= op;
      req_index <= idx;
      req_nth <= nth;
      req_fill_value <= fv;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predicted = bitmap_answer(op, idx, nth, fv);
      answers_due.push_back(known ? known_answer : predicted);
      @(negedge clock);
   endtask

   // only while nothing is in flight
   task automatic write_active_bytes(input logic [ACT_W-1:0] value);
      while (answers_due.size() != 0 || busy !== 1'b0) @(negedge clock);
      csr_valid <= 1'b1;
      csr_active_bytes <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      active_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin : result_check
      answer_type got;
      answer_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         got = {rsp_status, rsp_bit_value, rsp_position, rsp_ones_count};
         if (answers_due.size() == 0) begin
            note_mismatch($sformatf("unexpected result: status %0d bit %0d position %0d count %0d",
                                    got.status, got.bit_value, got.position, got.ones_count));
         end else begin
            want = answers_due.pop_front();
            if (got !== want)
               note_mismatch($sformatf({"expected status %0d bit %0d position %0d count %0d, ",
                                        "got status %0d bit %0d position %0d count %0d"},
                                       want.status, want.bit_value, want.position,
                                       want.ones_count, got.status, got.bit_value,
                                       got.position, got.ones_count));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : stimulus
      script_row_type     script [$];
      int                 act;
      int                 boundary;
      int                 idle_pct;
      int                 hot_base;
      int                 total;
      int                 pick;
      logic [OP_W-1:0]    op;
      logic [INDEX_W-1:0] idx;
      logic [NTH_W-1:0]   nth;
      logic               fv;

      for (int b = 0; b < STORE_BYTES; b++) bit_bytes[b] = 8'h00;
      active_limit = '0;

      // store empty after reset, active bytes still zero
      script.push_back(known_row(OP_TEST, 0, 0, 1'b0, 1'b0, 1'b0, 0, 0));
      script.push_back(known_row(OP_RANK, 4095, 0, 1'b0, 1'b0, 1'b0, 0, 0));
      script.push_back(known_row(OP_SELECT, 0, 0, 1'b0, 1'b1, 1'b0, 0, 0));
      script.push_back(known_row(OP_SELECT, 0, 1, 1'b0, 1'b1, 1'b0, 0, 0));
      script.push_back(known_row(OP_FILL, 0, 0, 1'b1, 1'b0, 1'b0, 0, 0));
      script.push_back(known_row(OP_RANK, 4095, 0, 1'b0, 1'b0, 1'b0, 0, 0));
      // active bytes beyond the store saturate
      script.push_back(csr_row(1023));
      script.push_back(known_row(OP_FILL, 0, 0, 1'b1, 1'b0, 1'b0, 0, 0));
      script.push_back(known_row(OP_RANK, 4095, 0, 1'b0, 1'b0, 1'b0, 0, 4096));
      script.push_back(known_row(OP_SELECT, 0, 4096, 1'b0, 1'b0, 1'b0, 4095, 0));
      script.push_back(known_row(OP_SELECT, 4095, 8191, 1'b1, 1'b1, 1'b0, 0, 0));
      script.push_back(known_row(OP_TEST, 4095, 0, 1'b0, 1'b0, 1'b1, 0, 0));
      script.push_back(known_row(OP_CLEAR, 0, 0, 1'b0, 1'b0, 1'b0, 0, 0));
      script.push_back(known_row(OP_SELECT, 0, 1, 1'b0, 1'b0, 1'b0, 1, 0));
      script.push_back(known_row(OP_FILL, 0, 0, 1'b0, 1'b0, 1'b0, 0, 0));
      script.push_back(known_row(OP_SET, 4095, 0, 1'b0, 1'b0, 1'b0, 0, 0));
      script.push_back(known_row(OP_SELECT, 0, 1, 1'b0, 1'b0, 1'b0, 4095, 0));
      script.push_back(known_row(OP_RANK, 4094, 0, 1'b0, 1'b0, 1'b0, 0, 0));
      script.push_back(known_row(OP_UNDEF7, 4095, 8191, 1'b1, 1'b0, 1'b0, 0, 0));
      script.push_back(known_row(OP_UNDEF6, 0, 1, 1'b1, 1'b0, 1'b0, 0, 0));
      script.push_back(known_row(OP_RANK, 4095, 0, 1'b0, 1'b0, 1'b0, 0, 1));
      script.push_back(csr_row(1));
      script.push_back(known_row(OP_FILL, 0, 0, 1'b1, 1'b0, 1'b0, 0, 0));
      // across the first word boundary
      script.push_back(plain_row(OP_SET, 64, 0, 1'b0));
      script.push_back(plain_row(OP_RANK, 63, 0, 1'b0));
      script.push_back(plain_row(OP_SELECT, 0, 9, 1'b0));
      script.push_back(plain_row(OP_SELECT, 0, 10, 1'b0));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].csr_write) begin
            start <= 1'b0;
            write_active_bytes(script[i].csr_value);
         end else begin
            issue_request(script[i].op, script[i].index, script[i].nth, script[i].fill_value,
                          script[i].known, script[i].answer);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         start <= 1'b0;
         case (phase)
            0: act = 512;
            1: act = 0;
            2: act = 1023;
            3: act = 1;
            4: act = $urandom_range(2, 1023);
            5: act = 511;
            6: act = $urandom_range(0, 512);
            default: act = 64;
         endcase
         write_active_bytes(ACT_W'(act));
         boundary = ((act > STORE_BYTES) ? STORE_BYTES : act) * 8;
         idle_pct = (phase % 4 == 1) ? 46 : (phase % 4 == 3) ? 9 : 0;
         hot_base = $urandom_range(0, CAPACITY_BITS - 1);

         repeat (ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 99) < idle_pct) begin
               start <= 1'b0;
               repeat ($urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(1, 80))
                  @(negedge clock);
            end

            pick = $urandom_range(0, 99);
            if (pick < 14) op = OP_TEST;
            else if (pick < 38) op = OP_SET;
            else if (pick < 52) op = OP_CLEAR;
            else if (pick < 70) op = OP_SELECT;
            else if (pick < 88) op = OP_RANK;
            else if (pick < 96) op = OP_FILL;
            else if (pick < 98) op = OP_UNDEF6;
            else op = OP_UNDEF7;

            // positions cluster at the ends, the fill edge and a hot window
            case ($urandom_range(0, 9))
               0: idx = $urandom_range(0, 1) ? '1 : '0;
               1, 2: idx = INDEX_W'(boundary - 8 + $urandom_range(0, 15));
               3, 4, 5: idx = INDEX_W'(hot_base + $urandom_range(0, 127));
               default: idx = INDEX_W'($urandom_range(0, CAPACITY_BITS - 1));
            endcase

            // mostly an nth that exists, plus zero, just past the end and noise
            total = ones_through(CAPACITY_BITS - 1);
            case ($urandom_range(0, 9))
               0: nth = '0;
               1: nth = NTH_W'($urandom);
               2: nth = NTH_W'(total + $urandom_range(0, 2));
               default: nth = NTH_W'((total == 0) ? $urandom_range(1, 3)
                                                  : $urandom_range(1, total));
            endcase

            fv = 1'($urandom_range(0, 1));
            issue_request(op, idx, nth, fv, 1'b0, '0);
         end
      end

      start <= 1'b0;
      while (answers_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
